[rtl/cwe_pkg.sv]
package cwe_pkg;

  // word and alphabet geometry, fixed by the port widths
  localparam int MAX_LEN    = 16;
  localparam int MAX_RANGES = 4;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 4;
  localparam int LEN_W      = 5;
  localparam int RIDX_W     = 2;
  localparam int RCNT_W     = 3;
  localparam int RSZ_W      = 9;
  localparam int SUM_W      = 11;
  localparam int SUM_IDX_W  = 4;
  localparam int REM_W      = 11;
  localparam int OFF_W      = 64;
  localparam int PW_W       = OFF_W + 1;
  localparam int ALU_W      = 76;
  localparam int CNT_W      = 6;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register values after reset
  localparam logic [LEN_W-1:0]      RST_MIN_LEN   = 5'd1;
  localparam logic [LEN_W-1:0]      RST_MAX_LEN   = 5'd8;
  localparam logic [RCNT_W-1:0]     RST_RANGE_CNT = 3'd1;
  localparam logic [CFG_DATA_W-1:0] RST_FIRSTS    = 32'd97;
  localparam logic [CFG_DATA_W-1:0] RST_LASTS     = 32'd122;
  localparam logic [CHAR_W-1:0]     RST_CHAR      = 8'd97;
  localparam logic [LEN_W-1:0]      RST_CUR_LEN   = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN   = 3'd0,
    CFG_MAX_LEN   = 3'd1,
    CFG_RANGE_CNT = 3'd2,
    CFG_FIRSTS    = 3'd3,
    CFG_LASTS     = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_SET     = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POW,
    S_MUL,
    S_CMP,
    S_DCHK,
    S_DIV,
    S_DWR,
    S_ADV,
    S_EMIT
  } state_t;

  // one stored digit of the word
  typedef struct packed {
    logic [RIDX_W-1:0] rng;
    logic [CHAR_W-1:0] off;
    logic [CHAR_W-1:0] chr;
  } dig_t;

  // write request into the digit store
  typedef struct packed {
    logic             clr;
    logic             we;
    logic [POS_W-1:0] addr;
    dig_t             data;
  } dig_wr_t;

endpackage

[rtl/cwe_alu.sv]
module cwe_alu (
  input  logic [cwe_pkg::ALU_W-1:0] opa,
  input  logic [cwe_pkg::ALU_W-1:0] opb,
  input  logic                      sub,
  output logic [cwe_pkg::ALU_W-1:0] res,
  output logic                      carry
);

  localparam int W = cwe_pkg::ALU_W;

  logic [W:0] full;

  // subtract is add of the complement plus one; carry set means opa >= opb
  assign full  = {1'b0, opa} + {1'b0, opb ^ {W{sub}}} + (W+1)'(sub);
  assign res   = full[W-1:0];
  assign carry = full[W];

endmodule

[rtl/cwe_digits.sv]
module cwe_digits (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cwe_pkg::dig_wr_t          wr,
  input  logic [cwe_pkg::POS_W-1:0] rd_addr,
  output cwe_pkg::dig_t             rd_data
);

  cwe_pkg::dig_t ent_r   [cwe_pkg::MAX_LEN];
  cwe_pkg::dig_t ent_nxt [cwe_pkg::MAX_LEN];

  // clear loads every entry with the base digit
  always_comb begin
    ent_nxt = ent_r;
    if (wr.clr) begin
      for (int i = 0; i < cwe_pkg::MAX_LEN; i++) begin
        ent_nxt[i] = wr.data;
      end
    end else if (wr.we) begin
      ent_nxt[wr.addr] = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cwe_pkg::MAX_LEN; i++) begin
        ent_r[i].rng <= '0;
        ent_r[i].off <= '0;
        ent_r[i].chr <= cwe_pkg::RST_CHAR;
      end
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign rd_data = ent_r[rd_addr];

endmodule

[rtl/charset_word_enumerator_top.sv]
// advance steps the digits from the rightmost, carrying into the next, and set
//   runs its multiplies, compares and divides on one shared 76-bit adder stepped by
//   the sequencer
// then one character per cycle, leftmost first; an empty word gives one result
// busy stays high until the last character is on the outputs; results cannot be stalled
// reset (synchronous, rst_n low) restores the register defaults and the word "a"
module charset_word_enumerator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [cwe_pkg::OFF_W-1:0]      in_offset,
  // result channel
  output logic                           out_valid,
  output logic [cwe_pkg::CHAR_W-1:0]     out_char_code,
  output logic [cwe_pkg::POS_W-1:0]      out_position,
  output logic [cwe_pkg::LEN_W-1:0]      out_word_length,
  output logic                           out_last,
  output logic                           out_ok,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cwe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwe_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = cwe_pkg::LEN_W;
  localparam int CHAR_W = cwe_pkg::CHAR_W;
  localparam int POS_W  = cwe_pkg::POS_W;
  localparam int RCNT_W = cwe_pkg::RCNT_W;
  localparam int RIDX_W = cwe_pkg::RIDX_W;
  localparam int RSZ_W  = cwe_pkg::RSZ_W;
  localparam int SUM_W  = cwe_pkg::SUM_W;
  localparam int REM_W  = cwe_pkg::REM_W;
  localparam int OFF_W  = cwe_pkg::OFF_W;
  localparam int PW_W   = cwe_pkg::PW_W;
  localparam int ALU_W  = cwe_pkg::ALU_W;
  localparam int CNT_W  = cwe_pkg::CNT_W;
  localparam int NR     = cwe_pkg::MAX_RANGES;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  cwe_pkg::state_t state_r, state_nxt;

  // configuration
  logic [LEN_W-1:0]               min_len_r, min_len_nxt;
  logic [LEN_W-1:0]               max_len_r, max_len_nxt;
  logic [RCNT_W-1:0]              rcnt_r, rcnt_nxt;
  logic [cwe_pkg::CFG_DATA_W-1:0] firsts_r, firsts_nxt;
  logic [cwe_pkg::CFG_DATA_W-1:0] lasts_r, lasts_nxt;

  // word length and working datapath
  logic [LEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;        // remaining offset, then quotient
  logic [SUM_W-1:0]   sum_r, sum_nxt;        // alphabet size latched per set
  logic [PW_W-1:0]    p_r, p_nxt;            // alphabet size to the length, saturated
  logic [LEN_W-1:0]   pw_r, pw_nxt;          // multiplications left for the first power
  logic [ALU_W-1:0]   acc_r, acc_nxt;        // shift-add product
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;        // bit step of multiply or divide
  logic [REM_W-1:0]   rem_r, rem_nxt;        // divide remainder
  logic [LEN_W-1:0]   d_r, d_nxt;            // digit position
  logic               srch_r, srch_nxt;      // length search under way
  logic               ok_r, ok_nxt;
  logic [POS_W-1:0]   emit_i_r, emit_i_nxt;

  // result registers
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ok_r, out_ok_nxt;

  // ---------------------------------------------------------------------------
  // alphabet decode from the range registers
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] rfirst [NR];
  logic [CHAR_W-1:0] rlast  [NR];
  logic [CHAR_W-1:0] rlo    [NR];
  logic [CHAR_W-1:0] rhi    [NR];
  logic [RSZ_W-1:0]  rsz    [NR];
  logic [RCNT_W-1:0] nr;
  logic [SUM_W-1:0]  alpha_sum;
  logic [LEN_W-1:0]  size_eff;
  logic [LEN_W-1:0]  lo_len;

  // reversed bounds are swapped, so each range is lo..hi
  always_comb begin
    for (int i = 0; i < NR; i++) begin
      rfirst[i] = firsts_r[i*CHAR_W +: CHAR_W];
      rlast[i]  = lasts_r[i*CHAR_W +: CHAR_W];
      rlo[i]    = (rfirst[i] < rlast[i]) ? rfirst[i] : rlast[i];
      rhi[i]    = (rfirst[i] < rlast[i]) ? rlast[i] : rfirst[i];
      rsz[i]    = RSZ_W'(rhi[i]) - RSZ_W'(rlo[i]) + RSZ_W'(1);
    end
  end

  // range count clamped to 1..4, max length clamped to 1..16, min length capped at the max
  always_comb begin
    if (rcnt_r == '0) begin
      nr = RCNT_W'(1);
    end else if (rcnt_r > RCNT_W'(NR)) begin
      nr = RCNT_W'(NR);
    end else begin
      nr = rcnt_r;
    end
    if (max_len_r == '0) begin
      size_eff = LEN_W'(1);
    end else if (max_len_r > LEN_W'(cwe_pkg::MAX_LEN)) begin
      size_eff = LEN_W'(cwe_pkg::MAX_LEN);
    end else begin
      size_eff = max_len_r;
    end
    lo_len = (min_len_r < size_eff) ? min_len_r : size_eff;
  end

  always_comb begin
    alpha_sum = '0;
    for (int i = 0; i < NR; i++) begin
      if (RCNT_W'(i) < nr) begin
        alpha_sum = alpha_sum + SUM_W'(rsz[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared adder and digit store
  // ---------------------------------------------------------------------------
  logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub, alu_carry;
  cwe_pkg::dig_wr_t   dwr;
  cwe_pkg::dig_t      rd;
  logic [POS_W-1:0]   rd_addr;

  cwe_alu u_alu (
    .opa   (alu_a),
    .opb   (alu_b),
    .sub   (alu_sub),
    .res   (alu_y),
    .carry (alu_carry)
  );

  cwe_digits u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (dwr),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  // ---------------------------------------------------------------------------
  // digit mapping: remainder to range and offset within it
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0]  map_ch;
  logic [RIDX_W-1:0] map_r;
  logic              map_go;
  logic [CHAR_W-1:0] map_char;

  always_comb begin
    map_ch = rem_r;
    map_r  = '0;
    map_go = 1'b1;
    for (int i = 0; i < NR - 1; i++) begin
      if (map_go && (RCNT_W'(i + 1) < nr) && (map_ch >= REM_W'(rsz[i]))) begin
        map_ch = map_ch - REM_W'(rsz[i]);
        map_r  = RIDX_W'(i + 1);
      end else begin
        map_go = 1'b0;
      end
    end
    map_char = rlo[map_r] + map_ch[CHAR_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // advance step on the digit at d_r: bump offset, move to next range or wrap
  // stale digits past the range count carry like the last digit value
  // ---------------------------------------------------------------------------
  logic [RIDX_W-1:0] adv_r;
  logic [CHAR_W-1:0] adv_off;
  logic              adv_done;
  logic [CHAR_W-1:0] adv_char;

  always_comb begin
    if ((RCNT_W'(rd.rng) < nr) && ((RSZ_W'(rd.off) + RSZ_W'(1)) < rsz[rd.rng])) begin
      adv_r    = rd.rng;
      adv_off  = rd.off + CHAR_W'(1);
      adv_done = 1'b1;
    end else if ((RCNT_W'(rd.rng) + RCNT_W'(1)) < nr) begin
      adv_r    = rd.rng + RIDX_W'(1);
      adv_off  = '0;
      adv_done = 1'b1;
    end else begin
      adv_r    = '0;
      adv_off  = '0;
      adv_done = 1'b0;
    end
    adv_char = rlo[adv_r] + adv_off;
  end

  // ---------------------------------------------------------------------------
  // misc decode
  // ---------------------------------------------------------------------------
  logic                         accept;
  logic                         last_char;
  logic [LEN_W-1:0]             emit_addr;
  logic [cwe_pkg::SUM_IDX_W-1:0] mb_idx;
  logic [REM_W:0]               rem2;

  assign busy      = (state_r != cwe_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;    // registers are always writable

  // leftmost character lives at the highest index
  assign emit_addr = cur_len_r - LEN_W'(1) - LEN_W'(emit_i_r);
  assign last_char = (cur_len_r == '0) || ((LEN_W'(emit_i_r) + LEN_W'(1)) == cur_len_r);
  assign rd_addr   = (state_r == cwe_pkg::S_ADV) ? d_r[POS_W-1:0] : emit_addr[POS_W-1:0];

  // multiplier walks the alphabet size msb first
  assign mb_idx = cwe_pkg::SUM_IDX_W'(SUM_W - 1) - cnt_r[cwe_pkg::SUM_IDX_W-1:0];
  assign rem2   = {rem_r, off_r[OFF_W-1]};

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_comb begin
    min_len_nxt = min_len_r;
    max_len_nxt = max_len_r;
    rcnt_nxt    = rcnt_r;
    firsts_nxt  = firsts_r;
    lasts_nxt   = lasts_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cwe_pkg::cfg_idx_t'(cfg_index))
        cwe_pkg::CFG_MIN_LEN:   min_len_nxt = cfg_data[LEN_W-1:0];
        cwe_pkg::CFG_MAX_LEN:   max_len_nxt = cfg_data[LEN_W-1:0];
        cwe_pkg::CFG_RANGE_CNT: rcnt_nxt    = cfg_data[RCNT_W-1:0];
        cwe_pkg::CFG_FIRSTS:    firsts_nxt  = cfg_data;
        cwe_pkg::CFG_LASTS:     lasts_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cwe_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == cwe_pkg::CMD_ADVANCE) ? cwe_pkg::S_ADV : cwe_pkg::S_POW;
        end
      end
      cwe_pkg::S_POW: begin
        state_nxt = (pw_r == '0) ? cwe_pkg::S_CMP : cwe_pkg::S_MUL;
      end
      cwe_pkg::S_MUL: begin
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = srch_r ? cwe_pkg::S_CMP : cwe_pkg::S_POW;
        end
      end
      cwe_pkg::S_CMP: begin
        if (!alu_carry) begin
          state_nxt = cwe_pkg::S_DCHK;
        end else if (cur_len_r >= size_eff) begin
          state_nxt = cwe_pkg::S_EMIT;
        end else begin
          state_nxt = cwe_pkg::S_MUL;
        end
      end
      cwe_pkg::S_DCHK: begin
        if ((off_r == '0) || (d_r == cur_len_r)) begin
          state_nxt = cwe_pkg::S_EMIT;
        end else begin
          state_nxt = cwe_pkg::S_DIV;
        end
      end
      cwe_pkg::S_DIV: begin
        if (cnt_r == CNT_W'(OFF_W - 1)) begin
          state_nxt = cwe_pkg::S_DWR;
        end
      end
      cwe_pkg::S_DWR: begin
        state_nxt = cwe_pkg::S_DCHK;
      end
      cwe_pkg::S_ADV: begin
        if ((d_r >= size_eff) || (d_r >= cur_len_r) || adv_done) begin
          state_nxt = cwe_pkg::S_EMIT;
        end
      end
      cwe_pkg::S_EMIT: begin
        if (last_char) begin
          state_nxt = cwe_pkg::S_IDLE;
        end
      end
      default: state_nxt = cwe_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_len_nxt   = cur_len_r;
    off_nxt       = off_r;
    sum_nxt       = sum_r;
    p_nxt         = p_r;
    pw_nxt        = pw_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    srch_nxt      = srch_r;
    ok_nxt        = ok_r;
    emit_i_nxt    = emit_i_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_pos_nxt   = out_pos_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_ok_nxt    = out_ok_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    dwr           = '0;

    unique case (state_r)
      cwe_pkg::S_IDLE: begin
        if (accept) begin
          d_nxt      = '0;
          emit_i_nxt = '0;
          if (in_cmd == cwe_pkg::CMD_ADVANCE) begin
            // a shortened max length clips the current word first
            cur_len_nxt = (cur_len_r > size_eff) ? size_eff : cur_len_r;
          end else begin
            // set starts from the base word at the shortest length
            off_nxt       = in_offset;
            sum_nxt       = alpha_sum;
            p_nxt         = PW_W'(1);
            pw_nxt        = lo_len;
            cur_len_nxt   = lo_len;
            srch_nxt      = 1'b0;
            dwr.clr       = 1'b1;
            dwr.data.rng  = '0;
            dwr.data.off  = '0;
            dwr.data.chr  = rlo[0];
          end
        end
      end
      cwe_pkg::S_POW: begin
        if (pw_r != '0) begin
          pw_nxt  = pw_r - LEN_W'(1);
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      cwe_pkg::S_MUL: begin
        alu_a   = {acc_r[ALU_W-2:0], 1'b0};
        alu_b   = sum_r[mb_idx] ? ALU_W'(p_r) : '0;
        acc_nxt = alu_y;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          cnt_nxt = '0;
          // anything at or past 2^64 exceeds every offset, so saturate there
          if (|alu_y[ALU_W-1:OFF_W]) begin
            p_nxt = {1'b1, {OFF_W{1'b0}}};
          end else begin
            p_nxt = {1'b0, alu_y[OFF_W-1:0]};
          end
        end
      end
      cwe_pkg::S_CMP: begin
        // offset - power: no carry means the word fits this length
        alu_a   = ALU_W'(off_r);
        alu_b   = ALU_W'(p_r);
        alu_sub = 1'b1;
        if (alu_carry) begin
          if (cur_len_r >= size_eff) begin
            // offset beyond capacity: base word at the shortest length
            cur_len_nxt = lo_len;
            ok_nxt      = 1'b0;
          end else begin
            off_nxt     = alu_y[OFF_W-1:0];
            cur_len_nxt = cur_len_r + LEN_W'(1);
            srch_nxt    = 1'b1;
            acc_nxt     = '0;
            cnt_nxt     = '0;
          end
        end
      end
      cwe_pkg::S_DCHK: begin
        if ((off_r == '0) || (d_r == cur_len_r)) begin
          ok_nxt = 1'b1;
        end else begin
          rem_nxt = '0;
          cnt_nxt = '0;
        end
      end
      cwe_pkg::S_DIV: begin
        // restoring divide, one quotient bit a cycle shifted into the offset
        alu_a   = ALU_W'(rem2);
        alu_b   = ALU_W'(sum_r);
        alu_sub = 1'b1;
        rem_nxt = alu_carry ? alu_y[REM_W-1:0] : rem2[REM_W-1:0];
        off_nxt = {off_r[OFF_W-2:0], alu_carry};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      cwe_pkg::S_DWR: begin
        dwr.we       = 1'b1;
        dwr.addr     = d_r[POS_W-1:0];
        dwr.data.rng = map_r;
        dwr.data.off = map_ch[CHAR_W-1:0];
        dwr.data.chr = map_char;
        d_nxt        = d_r + LEN_W'(1);
      end
      cwe_pkg::S_ADV: begin
        if (d_r >= size_eff) begin
          // every position wrapped at full length: space exhausted
          ok_nxt = 1'b0;
        end else if (d_r >= cur_len_r) begin
          // every position wrapped: the word grows by one
          cur_len_nxt = cur_len_r + LEN_W'(1);
          ok_nxt      = 1'b1;
        end else begin
          dwr.we       = 1'b1;
          dwr.addr     = d_r[POS_W-1:0];
          dwr.data.rng = adv_r;
          dwr.data.off = adv_off;
          dwr.data.chr = adv_char;
          if (adv_done) begin
            ok_nxt = 1'b1;
          end else begin
            d_nxt = d_r + LEN_W'(1);
          end
        end
      end
      cwe_pkg::S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = (cur_len_r == '0) ? '0 : rd.chr;
        out_pos_nxt   = emit_i_r;
        out_len_nxt   = cur_len_r;
        out_last_nxt  = last_char;
        out_ok_nxt    = ok_r;
        emit_i_nxt    = emit_i_r + POS_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cwe_pkg::S_IDLE;
      min_len_r   <= cwe_pkg::RST_MIN_LEN;
      max_len_r   <= cwe_pkg::RST_MAX_LEN;
      rcnt_r      <= cwe_pkg::RST_RANGE_CNT;
      firsts_r    <= cwe_pkg::RST_FIRSTS;
      lasts_r     <= cwe_pkg::RST_LASTS;
      cur_len_r   <= cwe_pkg::RST_CUR_LEN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_len_r   <= min_len_nxt;
      max_len_r   <= max_len_nxt;
      rcnt_r      <= rcnt_nxt;
      firsts_r    <= firsts_nxt;
      lasts_r     <= lasts_nxt;
      cur_len_r   <= cur_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    sum_r      <= sum_nxt;
    p_r        <= p_nxt;
    pw_r       <= pw_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    d_r        <= d_nxt;
    srch_r     <= srch_nxt;
    ok_r       <= ok_nxt;
    emit_i_r   <= emit_i_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_code   = out_char_r;
  assign out_position    = out_pos_r;
  assign out_word_length = out_len_r;
  assign out_last        = out_last_r;
  assign out_ok          = out_ok_r;

`ifndef NO_ASSERTIONS
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == cwe_pkg::S_EMIT))
    else $error("result strobe without an emit cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy once the final character is out");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cwe_pkg::S_DWR) |-> (rem_r < sum_r))
    else $error("divide remainder not below the alphabet size");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_len_r <= LEN_W'(cwe_pkg::MAX_LEN))
    else $error("word length beyond the digit store");
`endif

endmodule
